### hw/rtl/fcpn_pkg.sv
// ----------------------------------------------------------------------------
// fcpn_pkg
// Shared types, constants and trig helpers for the Fourier curve evaluator.
// ----------------------------------------------------------------------------
package fcpn_pkg;

  localparam int unsigned MaxHarm   = 16;
  localparam int unsigned HarmIdxW  = $clog2(MaxHarm);
  localparam int unsigned HarmCntW  = HarmIdxW + 1;
  localparam int unsigned TwoPiQ16  = 411775;

  localparam int unsigned InDataW   = 40;
  localparam int unsigned InUserW   = 2;
  localparam int unsigned OutDataW  = 96;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] RegPeriod = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSinCnt = 2'd2;
  localparam logic [CfgIdxW-1:0] RegCosCnt = 2'd3;

  localparam logic ReqWrite = 1'b0;
  localparam logic ReqEval  = 1'b1;
  localparam logic KindSin  = 1'b0;
  localparam logic KindCos  = 1'b1;

  typedef struct packed {
    logic                wr_coef;
    logic                load;
    logic                ph_clr;
    logic                ph_step;
    logic                trig;
    logic                mul;
    logic                imul;
    logic                acc;
    logic                nlo;
    logic                nhi;
    logic                fin;
    logic                pass;
    logic [HarmIdxW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [HarmCntW-1:0] ns;
    logic [HarmCntW-1:0] nc;
    logic                out_busy;
  } sts_t;

  function automatic logic [14:0] qwave(input logic [4:0] k);
    case (k)
      5'd0:  return 15'd0;
      5'd1:  return 15'd1606;
      5'd2:  return 15'd3196;
      5'd3:  return 15'd4756;
      5'd4:  return 15'd6270;
      5'd5:  return 15'd7723;
      5'd6:  return 15'd9102;
      5'd7:  return 15'd10394;
      5'd8:  return 15'd11585;
      5'd9:  return 15'd12665;
      5'd10: return 15'd13623;
      5'd11: return 15'd14449;
      5'd12: return 15'd15137;
      5'd13: return 15'd15679;
      5'd14: return 15'd16069;
      5'd15: return 15'd16305;
      default: return 15'd16384;
    endcase
  endfunction

  // x in [0,16384], Q.14 result
  function automatic logic [14:0] quarter_sine(input logic [14:0] x);
    logic [4:0]  seg;
    logic [9:0]  frac;
    logic [14:0] lo;
    logic [10:0] diff;
    logic [20:0] prod;
    seg  = x[14:10];
    frac = x[9:0];
    lo   = qwave(seg);
    diff = 11'(qwave(seg + 5'd1) - lo);
    prod = 21'(diff) * 21'(frac) + 21'd512;
    if (seg[4]) return 15'd16384;
    return lo + 15'(prod[20:10]);
  endfunction

  function automatic logic signed [15:0] fixed_sine(input logic [15:0] p);
    logic [14:0] r;
    logic [14:0] q;
    r = {1'b0, p[13:0]};
    q = p[14] ? quarter_sine(15'd16384 - r) : quarter_sine(r);
    return p[15] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [61:0] v);
    if (v > 62'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -62'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

### hw/rtl/fcpn_ctrl.sv
// ----------------------------------------------------------------------------
// fcpn_ctrl
// Sequencer: walks sine then cosine harmonics through the shared MAC.
// ----------------------------------------------------------------------------
module fcpn_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_req_i,
  output logic           in_ready_o,
  input  fcpn_pkg::sts_t sts_i,
  output fcpn_pkg::cmd_t cmd_o
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StChk  = 4'd1;
  localparam logic [3:0] StPh   = 4'd2;
  localparam logic [3:0] StSc   = 4'd3;
  localparam logic [3:0] StMul  = 4'd4;
  localparam logic [3:0] StIm   = 4'd5;
  localparam logic [3:0] StAcc  = 4'd6;
  localparam logic [3:0] StNlo  = 4'd7;
  localparam logic [3:0] StNhi  = 4'd8;
  localparam logic [3:0] StFin  = 4'd9;

  logic [3:0]                   state_q, state_d;
  logic [fcpn_pkg::HarmCntW-1:0] idx_q, idx_d;
  logic                         pass_q, pass_d;
  logic [fcpn_pkg::HarmCntW-1:0] cnt;

  assign cnt        = pass_q ? sts_i.nc : sts_i.ns;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pass_d  = pass_q;
    cmd_o   = '0;
    cmd_o.pass = pass_q;
    cmd_o.idx  = idx_q[fcpn_pkg::HarmIdxW-1:0];
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_req_i == fcpn_pkg::ReqEval) begin
            cmd_o.load = 1'b1;
            idx_d      = '0;
            pass_d     = fcpn_pkg::KindSin;
            state_d    = StChk;
          end else begin
            cmd_o.wr_coef = 1'b1;
          end
        end
      end
      StChk: begin
        if (idx_q < cnt) begin
          state_d = StPh;
        end else if (pass_q == fcpn_pkg::KindSin) begin
          pass_d       = fcpn_pkg::KindCos;
          idx_d        = '0;
          cmd_o.ph_clr = 1'b1;
        end else begin
          state_d = StNlo;
        end
      end
      StPh: begin
        cmd_o.ph_step = 1'b1;
        state_d       = StSc;
      end
      StSc: begin
        cmd_o.trig = 1'b1;
        state_d    = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StIm;
      end
      StIm: begin
        cmd_o.imul = 1'b1;
        state_d    = StAcc;
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        idx_d     = idx_q + 1'b1;
        state_d   = StChk;
      end
      StNlo: begin
        cmd_o.nlo = 1'b1;
        state_d   = StNhi;
      end
      StNhi: begin
        cmd_o.nhi = 1'b1;
        state_d   = StFin;
      end
      StFin: begin
        if (!sts_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pass_q  <= pass_d;
    end
  end

endmodule

### hw/rtl/fcpn_dp.sv
// ----------------------------------------------------------------------------
// fcpn_dp
// Datapath: config registers, coefficient tables, trig, MAC and output reg.
// ----------------------------------------------------------------------------
module fcpn_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  coef_kind_i,
  input  logic [3:0]            coef_index_i,
  input  logic signed [15:0]    coef_value_i,
  input  logic [16:0]           t_i,
  input  fcpn_pkg::cmd_t        cmd_i,
  output fcpn_pkg::sts_t        sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [15:0]           point_x_o,
  output logic signed [31:0]    point_y_o,
  output logic signed [31:0]    normal_x_o,
  output logic [15:0]           normal_y_o
);

  logic [15:0]        period_q;
  logic signed [15:0] height_q;
  logic [4:0]         sin_cnt_q, cos_cnt_q;
  logic signed [15:0] sin_tab_q [fcpn_pkg::MaxHarm];
  logic signed [15:0] cos_tab_q [fcpn_pkg::MaxHarm];

  logic [15:0]        t_q;
  logic [15:0]        px_q;
  logic [15:0]        ph_q;
  logic signed [15:0] s_q, c_q, coef_q;
  logic signed [31:0] py_q, pn_q;
  logic signed [37:0] nterm_q;
  logic signed [37:0] ysum_q;
  logic signed [40:0] nsum_q;
  logic signed [40:0] nlo_q;
  logic signed [61:0] nfull_q;
  logic               out_valid_q;

  logic [16:0]        t_cl;
  logic [32:0]        px_prod;
  logic signed [20:0] nhi;
  logic signed [61:0] nhi_prod;
  logic signed [61:0] y_rnd, n_rnd;

  assign sts_o.ns = (sin_cnt_q > 5'(fcpn_pkg::MaxHarm)) ? 5'(fcpn_pkg::MaxHarm) : sin_cnt_q;
  assign sts_o.nc = (cos_cnt_q > 5'(fcpn_pkg::MaxHarm)) ? 5'(fcpn_pkg::MaxHarm) : cos_cnt_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;

  assign t_cl    = (t_i > 17'd65536) ? 17'd65536 : t_i;
  assign px_prod = 33'(period_q) * 33'(t_cl) + 33'd32768;
  assign nhi     = nsum_q[40:20];
  assign nhi_prod = (62'(nhi) * $signed(62'(fcpn_pkg::TwoPiQ16))) <<< 20;
  assign y_rnd   = (62'(ysum_q) + 62'sd8192) >>> 14;
  assign n_rnd   = (nfull_q + 62'sd536870912) >>> 30;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= 16'd4096;
      height_q    <= '0;
      sin_cnt_q   <= '0;
      cos_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < fcpn_pkg::MaxHarm; k++) begin
        sin_tab_q[k] <= '0;
        cos_tab_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          fcpn_pkg::RegPeriod: period_q  <= cfg_data_i;
          fcpn_pkg::RegHeight: height_q  <= cfg_data_i;
          fcpn_pkg::RegSinCnt: sin_cnt_q <= cfg_data_i[4:0];
          fcpn_pkg::RegCosCnt: cos_cnt_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (cmd_i.wr_coef) begin
        if (coef_kind_i == fcpn_pkg::KindCos) cos_tab_q[coef_index_i] <= coef_value_i;
        else                                  sin_tab_q[coef_index_i] <= coef_value_i;
      end
      if (cmd_i.fin)        out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q    <= t_cl[15:0];
      px_q   <= px_prod[31:16];
      ph_q   <= '0;
      ysum_q <= 38'(height_q) <<< 14;
      nsum_q <= '0;
    end
    if (cmd_i.ph_clr)  ph_q <= '0;
    if (cmd_i.ph_step) ph_q <= ph_q + t_q;
    if (cmd_i.trig) begin
      s_q    <= fcpn_pkg::fixed_sine(ph_q);
      c_q    <= fcpn_pkg::fixed_sine(ph_q + 16'd16384);
      coef_q <= cmd_i.pass ? cos_tab_q[cmd_i.idx] : sin_tab_q[cmd_i.idx];
    end
    if (cmd_i.mul) begin
      py_q <= coef_q * (cmd_i.pass ? c_q : s_q);
      pn_q <= coef_q * (cmd_i.pass ? s_q : c_q);
    end
    if (cmd_i.imul) begin
      nterm_q <= 38'(pn_q) * $signed({1'b0, 5'(cmd_i.idx) + 5'd1});
      ysum_q  <= ysum_q + 38'(py_q);
    end
    if (cmd_i.acc) begin
      nsum_q <= cmd_i.pass ? nsum_q + 41'(nterm_q) : nsum_q - 41'(nterm_q);
    end
    if (cmd_i.nlo) begin
      nlo_q <= $signed({1'b0, nsum_q[19:0]}) * $signed(21'(fcpn_pkg::TwoPiQ16));
    end
    if (cmd_i.nhi) nfull_q <= nhi_prod + 62'(nlo_q);
    if (cmd_i.fin) begin
      point_x_o  <= px_q;
      point_y_o  <= fcpn_pkg::sat32(y_rnd);
      normal_x_o <= fcpn_pkg::sat32(n_rnd);
      normal_y_o <= period_q;
    end
  end

endmodule

### hw/rtl/fourier_curve_point_and_normal.sv
// ----------------------------------------------------------------------------
// fourier_curve_point_and_normal
// Fourier series curve evaluator: point and normal at parameter t.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tuser: req_type, coef_kind; tdata: idx, value, t
// m_axis    out  tvalid/tready          tdata: point_x, point_y, normal_x, normal_y
// cfg       in   cfg_valid_i/cfg_ready_o index, data
//
// Coefficient writes leave the input ready. Evaluate: the input stalls until
// the result is loaded into the output register; the cost of an item is set by
// the single shared multiply-accumulate stepping one harmonic at a time, over
// the sine harmonics and then the cosine harmonics.
// Reset clears tables, counts, and sets period to 1.0.
// The result sits in an output register; a new beat is taken while it waits,
// and the next result stalls only until that register drains.
module fourier_curve_point_and_normal (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // coef_index[3:0], coef_value[19:4], t[36:20]
  input  logic [1:0]  s_axis_tuser,   // req_type[0], coef_kind[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // point_x, point_y, normal_x, normal_y
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  fcpn_pkg::cmd_t     cmd;
  fcpn_pkg::sts_t     sts;
  logic [15:0]        point_x, normal_y;
  logic signed [31:0] point_y, normal_x;

  assign cfg_ready_o = 1'b1;
  assign m_axis_tdata = {normal_y, normal_x, point_y, point_x};

  fcpn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_req_i   (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fcpn_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .coef_kind_i  (s_axis_tuser[1]),
    .coef_index_i (s_axis_tdata[3:0]),
    .coef_value_i (s_axis_tdata[19:4]),
    .t_i          (s_axis_tdata[36:20]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .point_x_o    (point_x),
    .point_y_o    (point_y),
    .normal_x_o   (normal_x),
    .normal_y_o   (normal_y)
  );

endmodule

### hw/rtl/fcpn_chk.sv
// ----------------------------------------------------------------------------
// fcpn_chk
// Port-level checks for the Fourier curve evaluator.
// ----------------------------------------------------------------------------
module fcpn_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready)
    else $error("input taken during evaluation");

  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> s_axis_tready)
    else $error("coefficient write stalled input");

  // the reset branch is asynchronous; check valid low in the cycle after reset is sampled low
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid in reset");

endmodule

bind fourier_curve_point_and_normal fcpn_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### dv/fourier_curve_point_and_normal_tb.sv
// ----------------------------------------------------------------------------
// fourier_curve_point_and_normal_tb
// Self-checking bench for the Fourier curve evaluator. Coefficient writes and
// evaluate beats go through the input stream under several register settings.
// Each result field is checked against a fixed-point model or a typed value.
// ----------------------------------------------------------------------------
module fourier_curve_point_and_normal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned DrainWait  = 300;
  localparam int unsigned RandPerCfg = 320;
  localparam int QWave[17] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394, 11585,
                               12665, 13623, 14449, 15137, 15679, 16069, 16305, 16384};

  typedef struct packed {
    logic [15:0]        px;
    logic signed [31:0] py;
    logic signed [31:0] nx;
    logic [15:0]        ny;
  } curve_pt_t;

  typedef struct {
    logic        req;
    logic        kind;
    logic [3:0]  idx;
    logic [15:0] val;
    logic [16:0] t;
    bit          typed;
    curve_pt_t   want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  always #10 clk_i = ~clk_i;

  fourier_curve_point_and_normal dut (.*);

  // model state
  logic [15:0]        period_m;
  logic signed [15:0] height_m;
  logic [4:0]         sin_cnt_m, cos_cnt_m;
  logic signed [15:0] sin_tab[fcpn_pkg::MaxHarm];
  logic signed [15:0] cos_tab[fcpn_pkg::MaxHarm];

  curve_pt_t pending_pts[$];
  int unsigned errors = 0, n_writes = 0, n_evals = 0, n_results = 0;
  int unsigned cycles = 0;
  bit long_hold_done = 1'b0;

  function automatic int quarter_sin(int x);
    int seg, fr;
    seg = x >> 10;
    fr  = x & 1023;
    if (seg >= 16) return 16384;
    return QWave[seg] + (((QWave[seg+1] - QWave[seg]) * fr + 512) >>> 10);
  endfunction

  function automatic int sin_q14(int ph);
    int p, r;
    p = ph & 16'hFFFF;
    r = p & 16'h3FFF;
    case (p >> 14)
      0: return quarter_sin(r);
      1: return quarter_sin(16384 - r);
      2: return -quarter_sin(r);
      default: return -quarter_sin(16384 - r);
    endcase
  endfunction

  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic curve_pt_t eval_curve(logic [16:0] t_in);
    curve_pt_t r;
    longint ysum, nsum, a, b;
    int tt, ns, nc, ph;
    tt = (t_in > 17'd65536) ? 65536 : int'(t_in);
    ns = (sin_cnt_m > fcpn_pkg::MaxHarm) ? fcpn_pkg::MaxHarm : sin_cnt_m;
    nc = (cos_cnt_m > fcpn_pkg::MaxHarm) ? fcpn_pkg::MaxHarm : cos_cnt_m;
    ysum = longint'(height_m) * 16384;
    nsum = 0;
    for (int i = 1; i <= ns; i++) begin
      ph = (i * tt) & 16'hFFFF;
      a = sin_tab[i-1];
      ysum += a * sin_q14(ph);
      nsum -= i * (a * sin_q14(ph + 16384));
    end
    for (int i = 1; i <= nc; i++) begin
      ph = (i * tt) & 16'hFFFF;
      b = cos_tab[i-1];
      ysum += b * sin_q14(ph + 16384);
      nsum += i * (b * sin_q14(ph));
    end
    r.px = 16'((longint'(period_m) * tt + 32768) >> 16);
    r.py = clip32(round_half_up(ysum, 14));
    r.nx = clip32(round_half_up(nsum * fcpn_pkg::TwoPiQ16, 30));
    r.ny = period_m;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(stim_row_t row);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {row.kind, row.req};
    s_axis_tdata  <= {3'b0, row.t, row.val, row.idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (row.req == fcpn_pkg::ReqWrite) begin
      n_writes++;
      if (row.kind == fcpn_pkg::KindCos) cos_tab[row.idx] = row.val;
      else sin_tab[row.idx] = row.val;
    end else begin
      n_evals++;
      pending_pts.insert(pending_pts.size(), row.typed ? row.want : eval_curve(row.t));
    end
    if (pick_gap() != 0) begin
      int unsigned g;
      g = pick_gap() + 1;
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // valid is dropped by the caller once the last register is written
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      fcpn_pkg::RegPeriod: period_m = val;
      fcpn_pkg::RegHeight: height_m = val;
      fcpn_pkg::RegSinCnt: sin_cnt_m = val[4:0];
      default:             cos_cnt_m = val[4:0];
    endcase
  endtask

  // evaluations are long; the last result can trail the last write
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_results);
  endtask

  function automatic stim_row_t row_of(logic req, logic kind, logic [3:0] idx,
                                       logic [15:0] val, logic [16:0] t,
                                       bit typed, curve_pt_t want);
    stim_row_t r;
    r.req = req; r.kind = kind; r.idx = idx; r.val = val; r.t = t;
    r.typed = typed; r.want = want;
    return r;
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t r;
    int unsigned sel;
    r = row_of($urandom_range(0, 99) < 65 ? fcpn_pkg::ReqEval : fcpn_pkg::ReqWrite,
               1'($urandom), 4'($urandom), 16'($urandom), 17'($urandom), 1'b0, '0);
    sel = $urandom_range(0, 9);
    if (sel == 0) r.t = 17'd0;
    else if (sel == 1) r.t = 17'd65536;
    else if (sel == 2) r.t = 17'($urandom_range(65537, 131071));
    else if (sel < 7) r.t = 17'($urandom_range(0, 65535));
    return r;
  endfunction

  // output side: random backpressure plus one long hold
  int unsigned hold_left = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("** fourier_curve_point_and_normal: FAILED **");
      $finish;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      curve_pt_t got, want;
      got = {m_axis_tdata[15:0], m_axis_tdata[47:16], m_axis_tdata[79:48],
             m_axis_tdata[95:80]};
      n_results++;
      if (pending_pts.size() == 0) begin
        errors++;
        $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        want = pending_pts.pop_front();
        if (got.px !== want.px) report_mismatch("point_x", got.px, want.px);
        if (got.py !== want.py) report_mismatch("point_y", got.py, want.py);
        if (got.nx !== want.nx) report_mismatch("normal_x", got.nx, want.nx);
        if (got.ny !== want.ny) report_mismatch("normal_y", got.ny, want.ny);
      end
    end
    if (!long_hold_done && n_results == 60) begin
      long_hold_done <= 1'b1;
      hold_left <= 3000;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (pick_gap() == 0);
    end
  end

  stim_row_t directed[$];
  logic [15:0] phase_cfg[6][4] = '{
    '{16'd4096,  16'd0,      16'd0,  16'd0},
    '{16'd65535, 16'h7FFF,   16'd16, 16'd16},
    '{16'd0,     16'h8000,   16'd31, 16'd0},
    '{16'd4096,  16'hFC18,   16'd3,  16'd5},
    '{16'd12345, 16'h0800,   16'd0,  16'd31},
    '{16'd2048,  16'hF000,   16'd17, 16'd9}
  };

  task automatic add_row(stim_row_t row);
    directed.insert(directed.size(), row);
  endtask

  initial begin
    period_m = 16'd4096;
    height_m = '0;
    sin_cnt_m = '0;
    cos_cnt_m = '0;
    foreach (sin_tab[i]) begin
      sin_tab[i] = '0;
      cos_tab[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state: flat curve, period 1.0
    add_row(row_of(fcpn_pkg::ReqEval, fcpn_pkg::KindSin, 4'd0, 16'd0, 17'd0, 1,
                   '{16'd0, 32'sd0, 32'sd0, 16'd4096}));
    add_row(row_of(fcpn_pkg::ReqEval, fcpn_pkg::KindSin, 4'd0, 16'd0, 17'd65536, 1,
                   '{16'd4096, 32'sd0, 32'sd0, 16'd4096}));
    add_row(row_of(fcpn_pkg::ReqEval, fcpn_pkg::KindCos, 4'd0, 16'd0, 17'h1FFFF, 1,
                   '{16'd4096, 32'sd0, 32'sd0, 16'd4096}));
    add_row(row_of(fcpn_pkg::ReqEval, fcpn_pkg::KindSin, 4'd0, 16'd0, 17'd32768, 1,
                   '{16'd2048, 32'sd0, 32'sd0, 16'd4096}));
    add_row(row_of(fcpn_pkg::ReqWrite, fcpn_pkg::KindSin, 4'd0,  16'h7FFF, 17'd0, 0, '0));
    add_row(row_of(fcpn_pkg::ReqWrite, fcpn_pkg::KindSin, 4'd15, 16'h8000, 17'd0, 0, '0));
    add_row(row_of(fcpn_pkg::ReqWrite, fcpn_pkg::KindCos, 4'd0,  16'h8000, 17'd0, 0, '0));
    add_row(row_of(fcpn_pkg::ReqWrite, fcpn_pkg::KindCos, 4'd15, 16'h7FFF, 17'h1FFFF, 0,
                   '0));
    add_row(row_of(fcpn_pkg::ReqWrite, fcpn_pkg::KindSin, 4'd7,  16'h1000, 17'd0, 0, '0));
    add_row(row_of(fcpn_pkg::ReqWrite, fcpn_pkg::KindCos, 4'd3,  16'h0001, 17'd0, 0, '0));
    // counts still zero, so the tables do not show yet
    add_row(row_of(fcpn_pkg::ReqEval, fcpn_pkg::KindSin, 4'd0, 16'd0, 17'd16384, 1,
                   '{16'd1024, 32'sd0, 32'sd0, 16'd4096}));
    add_row(row_of(fcpn_pkg::ReqEval, fcpn_pkg::KindSin, 4'hF, 16'hFFFF, 17'd1, 0, '0));
    foreach (directed[i]) send_item(directed[i]);

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      for (int r = 0; r < 4; r++) write_reg(2'(r), phase_cfg[ph][r]);
      cfg_valid_i <= 1'b0;
      // a few fixed points under each setting
      send_item(row_of(fcpn_pkg::ReqEval, fcpn_pkg::KindSin, 4'd0, 16'd0, 17'd0, 0, '0));
      send_item(row_of(fcpn_pkg::ReqEval, fcpn_pkg::KindSin, 4'd0, 16'd0, 17'd65536, 0,
                       '0));
      send_item(row_of(fcpn_pkg::ReqEval, fcpn_pkg::KindSin, 4'd0, 16'd0, 17'h1FFFF, 0,
                       '0));
      send_item(row_of(fcpn_pkg::ReqEval, fcpn_pkg::KindSin, 4'd0, 16'd0, 17'd8192, 0,
                       '0));
      for (int k = 0; k < RandPerCfg; k++) send_item(rand_row());
    end

    wait_idle();
    $display("covered %0d coefficient writes and %0d evaluations over 6 register settings",
             n_writes, n_evals);
    $display("checked %0d result beats, %0d mismatches", n_results, errors);
    if (errors == 0) begin
      $display("** fourier_curve_point_and_normal: PASSED **");
    end else begin
      $display("** fourier_curve_point_and_normal: FAILED **");
    end
    $finish;
  end

endmodule
